[rtl/core/rtt_pkg.sv]
package rtt_pkg;

  // Request kinds carried in the input beat's tuser.
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIRE   = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // Result status carried in the output beat's tuser.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_NO_FIRE  = 2'd3
  } status_t;

  // A repeat count at or above this value never counts down.
  localparam logic [16:0] FOREVER_COUNT = 17'd99999;
  // Deadlines must lie strictly before now plus this horizon.
  localparam logic [31:0] HORIZON       = 32'd99999;
  // Wide enough to hold the largest slot count of 256.
  localparam int unsigned SLOT_EXT_W    = 9;

  localparam logic signed [32:0] DELAY_MIN = -33'sd65536;
  localparam logic signed [32:0] DELAY_MAX = 33'sd65535;

  // One timer slot as it sits in the slot memory.
  typedef struct packed {
    logic [30:0] start_time;
    logic [15:0] wait_time;
    logic [16:0] repeat_cnt;
    logic [15:0] tag;
  } slot_entry_t;

  // Write-side controls of the slot memory.
  typedef struct packed {
    logic wr;
    logic clr;
  } mem_ctl_t;

  // Input tdata layout, lowest field in the lowest bits.
  typedef struct packed {
    logic [2:0]  pad;
    logic [15:0] tag;
    logic [16:0] repeat_total;
    logic [15:0] wait_seconds;
    logic        force_delete;
    logic [3:0]  slot_index;
    logic [30:0] now_seconds;
  } in_beat_t;

  // Output tdata layout, lowest field in the lowest bits.
  typedef struct packed {
    logic [4:0]         pad;
    logic signed [16:0] next_delay;
    logic [3:0]         next_slot;
    logic               next_valid;
    logic [16:0]        fired_repeat;
    logic [15:0]        fired_tag;
    logic [3:0]         result_slot;
  } out_beat_t;

endpackage

[rtl/core/rtt_slot_mem.sv]
module rtt_slot_mem #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rtt_pkg::mem_ctl_t     ctl,
  input  logic [IDX_W-1:0]      wr_addr,
  input  rtt_pkg::slot_entry_t  wdata,
  input  logic [IDX_W-1:0]      rd_addr,
  output rtt_pkg::slot_entry_t  rd_data
);
  import rtt_pkg::*;

  slot_entry_t             mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   valid;
  slot_entry_t             rd_raw;
  logic                    rd_hit;

  // Payload array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wdata;
    end
    rd_raw <= mem[rd_addr];
  end

  // Per-entry valid bits give the cleared state without sweeping the array.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (ctl.wr) begin
        valid[wr_addr] <= 1'b1;
      end else if (ctl.clr) begin
        valid[wr_addr] <= 1'b0;
      end
      rd_hit <= valid[rd_addr];
    end
  end

  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

[rtl/core/rtt_ctrl.sv]
module rtt_ctrl #(
  parameter int unsigned SLOT_COUNT = 16,
  parameter int unsigned IDX_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire_en,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rtt_pkg::in_beat_t     in_beat,
  input  rtt_pkg::req_t         in_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rtt_pkg::out_beat_t    out_beat,
  output rtt_pkg::status_t      out_status,
  output rtt_pkg::mem_ctl_t     mem_ctl,
  output logic [IDX_W-1:0]      wr_addr,
  output rtt_pkg::slot_entry_t  wdata,
  output logic [IDX_W-1:0]      rd_addr,
  input  rtt_pkg::slot_entry_t  rd_data
);
  import rtt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_READ   = 6'b000010,
    S_MODIFY = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state;

  // Request held for the whole sequence.
  req_t        req_q;
  logic [30:0] now_q;
  logic [3:0]  idx_q;
  logic        force_q;
  logic [15:0] wait_q;
  logic [16:0] rep_q;
  logic [15:0] tag_q;

  // Outcome of the modify step.
  status_t     status_q;
  logic [3:0]  rslot_q;
  logic [15:0] ftag_q;
  logic [16:0] frep_q;

  // Earliest deadline and lowest free slot, as left by the last rescan.
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_slot;
  logic [31:0]       pend_due;
  logic              free_valid;
  logic [IDX_W-1:0]  free_slot;

  logic [IDX_W-1:0]  cnt;
  logic              probe_vld;
  logic [IDX_W-1:0]  probe_idx;

  out_beat_t         out_beat_r;
  status_t           out_status_r;

  logic [SLOT_EXT_W-1:0] idx_ext;
  logic                  idx_bad;
  logic [IDX_W-1:0]      idx_slot;

  status_t           mod_status;
  logic [3:0]        mod_rslot;
  logic [15:0]       mod_ftag;
  logic [16:0]       mod_frep;
  logic              retire_en;
  logic              retire_force;
  logic [IDX_W-1:0]  retire_addr;

  logic [31:0]       probe_due;
  logic              probe_hit;
  logic signed [32:0] delay_full;
  logic signed [16:0] delay_sat;
  logic              emit_go;

  function automatic logic [3:0] slot_lo4(input logic [IDX_W-1:0] s);
    logic [SLOT_EXT_W-1:0] e;
    e = SLOT_EXT_W'(s);
    return e[3:0];
  endfunction

  assign in_ready = (state == S_IDLE);

  assign idx_ext  = SLOT_EXT_W'(idx_q);
  assign idx_bad  = (idx_ext >= SLOT_EXT_W'(SLOT_COUNT));
  assign idx_slot = idx_ext[IDX_W-1:0];

  // Read address: the scanned entry, or the entry that the request modifies.
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = cnt;
    end else if (req_q == REQ_FIRE) begin
      rd_addr = pend_slot;
    end else begin
      rd_addr = idx_slot;
    end
  end

  // Modify step: the read data of the addressed entry is valid in S_MODIFY.
  always_comb begin
    mod_status   = ST_OK;
    mod_rslot    = '0;
    mod_ftag     = '0;
    mod_frep     = '0;
    retire_en    = 1'b0;
    retire_force = 1'b0;
    retire_addr  = idx_slot;
    mem_ctl      = '0;
    wr_addr      = free_slot;
    wdata        = '0;
    if (state == S_MODIFY) begin
      unique case (req_q)
        REQ_ADD: begin
          if (free_valid) begin
            mem_ctl.wr       = 1'b1;
            wr_addr          = free_slot;
            wdata.start_time = now_q;
            wdata.wait_time  = wait_q;
            wdata.repeat_cnt = rep_q;
            wdata.tag        = tag_q;
            mod_rslot        = slot_lo4(free_slot);
          end else begin
            mod_status = ST_FULL;
          end
        end
        REQ_DELETE: begin
          mod_rslot = idx_q;
          if (idx_bad) begin
            mod_status = ST_BAD_SLOT;
          end else begin
            retire_en    = 1'b1;
            retire_force = force_q;
            retire_addr  = idx_slot;
          end
        end
        REQ_FIRE: begin
          if (!fire_en || !pend_valid) begin
            mod_status = ST_NO_FIRE;
          end else begin
            mod_rslot   = slot_lo4(pend_slot);
            mod_ftag    = rd_data.tag;
            mod_frep    = rd_data.repeat_cnt;
            retire_en   = 1'b1;
            retire_addr = pend_slot;
          end
        end
        REQ_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
    if (retire_en) begin
      wr_addr = retire_addr;
      wdata   = rd_data;
      if ((rd_data.repeat_cnt <= 17'd1) || retire_force) begin
        mem_ctl.clr = 1'b1;
      end else begin
        mem_ctl.wr       = 1'b1;
        wdata.start_time = now_q;
        if (rd_data.repeat_cnt < FOREVER_COUNT) begin
          wdata.repeat_cnt = rd_data.repeat_cnt - 17'd1;
        end
      end
    end
  end

  // Rescan compare on the entry that returned from memory this cycle.
  assign probe_due = {1'b0, rd_data.start_time} + {16'b0, rd_data.wait_time};
  assign probe_hit = (rd_data.wait_time != '0) && (rd_data.start_time != '0) &&
                     (probe_due < pend_due);

  assign delay_full = $signed({1'b0, pend_due}) - $signed({2'b0, now_q});

  always_comb begin
    if (!pend_valid) begin
      delay_sat = '0;
    end else if (delay_full < DELAY_MIN) begin
      delay_sat = DELAY_MIN[16:0];
    end else if (delay_full > DELAY_MAX) begin
      delay_sat = DELAY_MAX[16:0];
    end else begin
      delay_sat = delay_full[16:0];
    end
  end

  assign emit_go = (state == S_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      pend_slot  <= '0;
      free_valid <= 1'b1;
      free_slot  <= '0;
      probe_vld  <= 1'b0;
      out_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      probe_vld <= (state == S_SCAN);
      probe_idx <= cnt;
      // A beat taken in the same cycle as a new one is loaded stays valid.
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q   <= in_req;
            now_q   <= in_beat.now_seconds;
            idx_q   <= in_beat.slot_index;
            force_q <= in_beat.force_delete;
            wait_q  <= in_beat.wait_seconds;
            rep_q   <= in_beat.repeat_total;
            tag_q   <= in_beat.tag;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_MODIFY;
        end
        S_MODIFY: begin
          status_q   <= mod_status;
          rslot_q    <= mod_rslot;
          ftag_q     <= mod_ftag;
          frep_q     <= mod_frep;
          pend_valid <= 1'b0;
          pend_slot  <= '0;
          pend_due   <= {1'b0, now_q} + HORIZON;
          free_valid <= 1'b0;
          free_slot  <= '0;
          cnt        <= '0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == IDX_W'(SLOT_COUNT - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid               <= 1'b1;
            out_status_r            <= status_q;
            out_beat_r.pad          <= '0;
            out_beat_r.result_slot  <= rslot_q;
            out_beat_r.fired_tag    <= ftag_q;
            out_beat_r.fired_repeat <= frep_q;
            out_beat_r.next_valid   <= pend_valid;
            out_beat_r.next_slot    <= pend_valid ? slot_lo4(pend_slot) : 4'd0;
            out_beat_r.next_delay   <= delay_sat;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Scan results; a probe is only ever live in S_SCAN and S_DRAIN.
      if (probe_vld) begin
        if (probe_hit) begin
          pend_valid <= 1'b1;
          pend_slot  <= probe_idx;
          pend_due   <= probe_due;
        end
        if (!free_valid && (rd_data.wait_time == '0)) begin
          free_valid <= 1'b1;
          free_slot  <= probe_idx;
        end
      end
    end
  end

  assign out_beat   = out_beat_r;
  assign out_status = out_status_r;

endmodule

[rtl/core/repeating_timer_table_top.sv]
// Each request runs idle, read, modify, scan, drain, emit; the result beat is loaded in emit once
//   the result register is free, and only then is a new request taken. The rescan in scan reads
//   the slot memory one entry per cycle through its single read port.
// Reset (rst, synchronous, active high): all slots free, nothing pending, firing enabled,
//   no result beat held. Reset clears per-slot valid bits at once, so no clearing pass.
module repeating_timer_table_top #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic         clk,
  input  logic         rst,
  // Request stream.
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata fields from bit 0 up: now_seconds[30:0], slot_index[34:31], force_delete[35],
  // wait_seconds[51:36], repeat_total[68:52], tag[84:69], zero padding[87:85].
  input  logic [87:0]  s_tdata,
  // tuser: req_type[1:0].
  input  logic [1:0]   s_tuser,
  // Result stream.
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata fields from bit 0 up: result_slot[3:0], fired_tag[19:4], fired_repeat[36:20],
  // next_valid[37], next_slot[41:38], next_delay[58:42], zero padding[63:59].
  output logic [63:0]  m_tdata,
  // tuser: status[1:0].
  output logic [1:0]   m_tuser,
  // Configuration port; firing_enabled lives at byte address 0.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rtt_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

  // The block is built around one slot memory holding start time, wait, repeat count
  // and tag of every slot. Each request goes through a short sequence: the addressed
  // entry is read, modified and written back, then every entry is read in turn to find
  // the earliest qualifying deadline and the lowest free slot. The free slot that the
  // rescan leaves behind serves the next add, so an add needs no search of its own.
  // Accesses never overlap on one entry, because the sequencer handles one request at
  // a time and the rescan reads only start after the write-back has landed.

  logic        fire_en;
  logic        cfg_wr;

  in_beat_t    in_beat;
  req_t        in_req;
  out_beat_t   out_beat;
  status_t     out_status;

  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  wr_addr;
  logic [IDX_W-1:0]  rd_addr;
  slot_entry_t       wdata;
  slot_entry_t       rd_data;

  // Configuration register. Only the lower word decodes to firing_enabled; a write to
  // the upper word is accepted and ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      fire_en <= 1'b1;
    end else if (cfg_wr) begin
      fire_en <= pwdata[0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {31'd0, fire_en};

  // Unpack the request beat.
  assign in_beat = in_beat_t'(s_tdata);
  assign in_req  = req_t'(s_tuser);

  rtt_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wdata   (wdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The sequencer also holds the result register, so a finished beat can wait for
  // m_tready without holding up the memory.
  rtt_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire_en    (fire_en),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_beat    (in_beat),
    .in_req     (in_req),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_beat   (out_beat),
    .out_status (out_status),
    .mem_ctl    (mem_ctl),
    .wr_addr    (wr_addr),
    .wdata      (wdata),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  assign m_tdata = out_beat;
  assign m_tuser = out_status;

endmodule

[rtl/core/rtt_checker.sv]
module rtt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import rtt_pkg::*;

  out_beat_t ob;
  status_t   st;

  assign ob = out_beat_t'(m_tdata);
  assign st = status_t'(m_tuser);

  // A result beat held back by the sink keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // One request at a time: after a request beat the block stops taking requests.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in progress");

  // With nothing pending the pending slot and delay read as zero.
  a_none_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !ob.next_valid |-> (ob.next_slot == 4'd0) && (ob.next_delay == '0))
    else $error("pending fields set with nothing pending");

  // Fired tag and count read as zero on every failed request.
  a_fire_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (st != ST_OK) |-> (ob.fired_tag == 16'd0) && (ob.fired_repeat == 17'd0))
    else $error("fire fields set on a failed request");

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat present after reset");

endmodule

bind repeating_timer_table_top rtt_checker u_rtt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

[tb/repeating_timer_table_top_test.sv]
`timescale 1ns / 100ps

module repeating_timer_table_top_test;
  import rtt_pkg::*;

  localparam int SLOTS = 16;
  // The only register, firing_enabled, sits at byte address 0.
  localparam logic [2:0] FIRE_EN_ADDR = 3'd0;
  // Counts at or above this value stay put when a timer repeats.
  localparam logic [16:0] ENDLESS = 17'd99999;
  // A deadline only qualifies if it lies strictly before now plus this window.
  localparam longint WINDOW = 99999;

  // One request as the driver sees it.
  typedef struct {
    req_t        kind;
    logic [30:0] now;
    logic [3:0]  slot;
    logic        force_del;
    logic [15:0] wait_s;
    logic [16:0] reps;
    logic [15:0] tag;
  } timer_req_t;

  // One result beat as the table should produce it.
  typedef struct {
    status_t            status;
    logic [3:0]         slot;
    logic [15:0]        tag;
    logic [16:0]        reps;
    logic               nxt_valid;
    logic [3:0]         nxt_slot;
    logic signed [16:0] nxt_delay;
  } timer_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  repeating_timer_table_top #(.SLOT_COUNT(SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 20 ns period; the first rising edge falls at 10 ns.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Our own copy of the timer table, kept in step with every accepted request beat.
  logic [30:0] t_start [SLOTS];
  logic [15:0] t_wait [SLOTS];
  logic [16:0] t_count [SLOTS];
  logic [15:0] t_tag [SLOTS];
  logic        due_valid;
  logic [3:0]  due_slot;
  logic        fire_enable;

  timer_req_t    pending_reqs[$];
  timer_result_t expected_results[$];
  timer_req_t    cur_req;
  logic          req_taken;
  int            items_total;
  int            results_seen;
  int            error_count;
  // While set, neither side inserts idle cycles.
  bit            steady;
  // Running clock used to give random requests a plausible, mostly rising time.
  logic [30:0]   sim_clock;

  // Frees a slot when its count has run out or the caller forces it, otherwise restarts
  // it at the current time and counts it down unless it repeats for ever.
  function automatic void retire_slot(int s, logic force_del, logic [30:0] now);
    if (t_count[s] <= 17'd1 || force_del) begin
      t_start[s] = '0;
      t_wait[s]  = '0;
      t_count[s] = '0;
      t_tag[s]   = '0;
    end else begin
      if (t_count[s] < ENDLESS)
        t_count[s] = t_count[s] - 17'd1;
      t_start[s] = now;
    end
  endfunction

  // Applies one request to the table copy, rescans for the earliest deadline and
  // returns the result beat that the block should send for it.
  function automatic timer_result_t apply_request(timer_req_t r);
    timer_result_t res;
    longint        best;
    longint        due;
    longint        delay;
    int            free_slot;
    res = '{status: ST_OK, slot: '0, tag: '0, reps: '0,
            nxt_valid: 1'b0, nxt_slot: '0, nxt_delay: '0};
    case (r.kind)
      REQ_ADD: begin
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--)
          if (t_wait[i] == '0)
            free_slot = i;
        if (free_slot < 0) begin
          res.status = ST_FULL;
        end else begin
          t_start[free_slot] = r.now;
          t_wait[free_slot]  = r.wait_s;
          t_count[free_slot] = r.reps;
          t_tag[free_slot]   = r.tag;
          res.slot = free_slot[3:0];
        end
      end
      REQ_DELETE: begin
        res.slot = r.slot;
        if (int'(r.slot) >= SLOTS)
          res.status = ST_BAD_SLOT;
        else
          retire_slot(r.slot, r.force_del, r.now);
      end
      REQ_FIRE: begin
        if (!fire_enable || !due_valid) begin
          res.status = ST_NO_FIRE;
        end else begin
          res.slot = due_slot;
          res.tag  = t_tag[due_slot];
          res.reps = t_count[due_slot];
          retire_slot(due_slot, 1'b0, r.now);
        end
      end
      default: ;
    endcase

    // Earliest qualifying deadline wins; the strict compare keeps the lowest index on a tie.
    best = longint'(r.now) + WINDOW;
    due_valid = 1'b0;
    due_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      due = longint'(t_start[i]) + longint'(t_wait[i]);
      if (t_wait[i] != '0 && t_start[i] != '0 && due < best) begin
        best = due;
        due_valid = 1'b1;
        due_slot = i[3:0];
      end
    end

    if (due_valid) begin
      delay = longint'(t_start[due_slot]) + longint'(t_wait[due_slot]) - longint'(r.now);
      if (delay < -65536)
        delay = -65536;
      if (delay > 65535)
        delay = 65535;
      res.nxt_valid = 1'b1;
      res.nxt_slot  = due_slot;
      res.nxt_delay = delay[16:0];
    end
    return res;
  endfunction

  function automatic bit take_break();
    return !steady && ($urandom_range(99, 0) < 35);
  endfunction

  task automatic check_field(string name, longint expected, longint actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      error_count++;
    end
  endtask

  // Request driver: a new beat goes out at the falling edge once the previous one has
  // been taken, unless an idle cycle is drawn.
  always @(negedge clk) begin
    in_beat_t beat;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && !take_break()) begin
        cur_req = pending_reqs.pop_front();
        beat = '0;
        beat.now_seconds  = cur_req.now;
        beat.slot_index   = cur_req.slot;
        beat.force_delete = cur_req.force_del;
        beat.wait_seconds = cur_req.wait_s;
        beat.repeat_total = cur_req.reps;
        beat.tag          = cur_req.tag;
        s_tdata  <= beat;
        s_tuser  <= cur_req.kind;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stalls at random like the sender.
  always @(negedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= !take_break();
  end

  // At each rising edge an accepted request beat updates the table copy, and an accepted
  // result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    out_beat_t     got;
    timer_result_t exp_res;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready)
        expected_results.push_back(apply_request(cur_req));
      if (m_tvalid && m_tready) begin
        results_seen++;
        got = out_beat_t'(m_tdata);
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no request outstanding");
          error_count++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("status", exp_res.status, m_tuser);
          check_field("result_slot", exp_res.slot, got.result_slot);
          check_field("fired_tag", exp_res.tag, got.fired_tag);
          check_field("fired_repeat", exp_res.reps, got.fired_repeat);
          check_field("next_valid", exp_res.nxt_valid, got.next_valid);
          check_field("next_slot", exp_res.nxt_slot, got.next_slot);
          check_field("next_delay", longint'(exp_res.nxt_delay), longint'(got.next_delay));
        end
      end
    end
  end

  task automatic push_req(req_t kind, logic [30:0] now, logic [3:0] slot, logic force_del,
                          logic [15:0] wait_s, logic [16:0] reps, logic [15:0] tag);
    timer_req_t r;
    r = '{kind: kind, now: now, slot: slot, force_del: force_del,
          wait_s: wait_s, reps: reps, tag: tag};
    pending_reqs.push_back(r);
    items_total++;
  endtask

  // Blocks until every queued request has produced its result, then adds a short pause.
  task automatic settle();
    while (results_seen != items_total)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes firing_enabled through the APB port and reads it straight back.
  task automatic set_firing(logic value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FIRE_EN_ADDR;
    pwdata  <= {31'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    fire_enable = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("prdata", {31'd0, value}, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Builds one random request. Time mostly creeps forward, with the odd jump back (so
  // deadlines can sit far ahead of now), the odd leap forward (so timers become badly
  // overdue), a rare fully random time and a rare time of zero.
  task automatic push_random(int add_pct);
    int          pick;
    int          sub;
    req_t        kind;
    logic [30:0] now;
    logic [15:0] wait_s;
    logic [16:0] reps;
    pick = $urandom_range(99, 0);
    if (pick < 2)
      sim_clock = sim_clock - 31'($urandom_range(100000, 0));
    else if (pick < 5)
      sim_clock = sim_clock + 31'($urandom_range(200000, 0));
    else if (pick < 6)
      sim_clock = 31'($urandom);
    else
      sim_clock = sim_clock + 31'($urandom_range(20, 0));
    now = ($urandom_range(99, 0) == 0) ? 31'd0 : sim_clock;

    pick = $urandom_range(99, 0);
    sub = $urandom_range(9, 0);
    if (pick < add_pct)
      kind = REQ_ADD;
    else if (sub < 4)
      kind = REQ_DELETE;
    else if (sub < 9)
      kind = REQ_FIRE;
    else
      kind = REQ_UNUSED;

    pick = $urandom_range(99, 0);
    if (pick < 10)
      wait_s = 16'd0;
    else if (pick < 20)
      wait_s = 16'hffff;
    else if (pick < 60)
      wait_s = 16'($urandom_range(200, 1));
    else
      wait_s = 16'($urandom_range(65535, 1));

    pick = $urandom_range(99, 0);
    if (pick < 30)
      reps = 17'($urandom_range(2, 0));
    else if (pick < 45)
      reps = ENDLESS;
    else if (pick < 70)
      reps = 17'($urandom_range(20, 3));
    else
      reps = 17'($urandom_range(99999, 0));

    push_req(kind, now, 4'($urandom_range(15, 0)), $urandom_range(99, 0) < 30,
             wait_s, reps, 16'($urandom_range(65535, 0)));
  endtask

  task automatic run_phase(int count, int add_pct, logic firing);
    set_firing(firing);
    for (int n = 0; n < count; n++)
      push_random(add_pct);
    settle();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_ADD;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cur_req  = '{kind: REQ_ADD, now: '0, slot: '0, force_del: 1'b0,
                 wait_s: '0, reps: '0, tag: '0};
    for (int i = 0; i < SLOTS; i++) begin
      t_start[i] = '0;
      t_wait[i]  = '0;
      t_count[i] = '0;
      t_tag[i]   = '0;
    end
    due_valid    = 1'b0;
    due_slot     = '0;
    fire_enable  = 1'b1;
    items_total  = 0;
    results_seen = 0;
    error_count  = 0;
    steady       = 1'b0;
    sim_clock    = 31'd1000;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening. Firing into an empty table gives nothing, and deleting a slot
    // that is already free simply clears it again.
    push_req(REQ_FIRE, 31'd5, 4'd0, 1'b0, 16'd0, 17'd0, 16'd0);
    push_req(REQ_DELETE, 31'd5, 4'd15, 1'b0, 16'd0, 17'd0, 16'd0);
    // A timer added at time zero takes slot 0 but is never picked as the next one due.
    push_req(REQ_ADD, 31'd0, 4'd0, 1'b0, 16'd1, 17'd2, 16'd0);
    // Fill the rest of the table. Slots 1 and 2 share a deadline, so the lower index
    // must win; slot 14 starts at the top of the time range and lies beyond the window.
    for (int i = 1; i < SLOTS; i++)
      push_req(REQ_ADD, (i == 14) ? 31'h7fffffff : 31'd1000, 4'd0, 1'b0,
               (i <= 2) ? 16'd50 : ((i == 15) ? 16'hffff : 16'(100 + i)),
               (i == 1) ? ENDLESS : ((i == 2) ? 17'd2 : 17'(i)),
               (i == 1) ? 16'hffff : 16'(i * 16'h0111));
    // One more add finds the table full.
    push_req(REQ_ADD, 31'd1001, 4'd0, 1'b0, 16'd7, 17'd3, 16'h5a5a);
    // The endless timer fires and restarts without counting down; then slot 2 fires and
    // drops from two firings to one.
    push_req(REQ_FIRE, 31'd1200, 4'd0, 1'b0, 16'd0, 17'd0, 16'd0);
    push_req(REQ_FIRE, 31'd1201, 4'd0, 1'b0, 16'd0, 17'd0, 16'd0);
    // Forced delete frees a slot; an unforced one on a counting timer restarts it.
    push_req(REQ_DELETE, 31'd1300, 4'd3, 1'b1, 16'd0, 17'd0, 16'd0);
    push_req(REQ_DELETE, 31'd1300, 4'd4, 1'b0, 16'd0, 17'd0, 16'd0);
    // The unused request kind changes nothing, but its far-later time drives the next
    // deadline well overdue, so the delay saturates at its low bound.
    push_req(REQ_UNUSED, 31'd200000, 4'd15, 1'b1, 16'hffff, ENDLESS, 16'hffff);
    settle();

    // With firing switched off a fire request delivers nothing.
    set_firing(1'b0);
    push_req(REQ_FIRE, 31'd200001, 4'd0, 1'b0, 16'd0, 17'd0, 16'd0);
    settle();

    // Random phases over both register settings. One leans hard on adds to keep the
    // table near full, and one runs with no idle cycles on either side.
    run_phase(200, 40, 1'b1);
    run_phase(100, 40, 1'b0);
    run_phase(250, 60, 1'b1);
    steady = 1'b1;
    run_phase(250, 35, 1'b1);
    steady = 1'b0;
    run_phase(200, 30, 1'b1);

    // Give any stray beat time to show up past the block's latency.
    repeat (40) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("repeating_timer_table_top test passed");
    end else begin
      $display("repeating_timer_table_top test failed");
    end
    $finish;
  end

  // Watchdog: the whole run needs well under a tenth of this.
  initial begin
    #20ms;
    $display("repeating_timer_table_top test failed");
    $finish;
  end

endmodule
